// File: sv/sil_pkg.sv
// sil_pkg: shared widths, kind and segment codes, register reset values
// and the section classifier for the section image layout core.
// No dependencies.
package sil_pkg;

   localparam int unsigned ADDR_WIDTH  = 64;
   localparam int unsigned ALIGN_WIDTH = 32;
   localparam int unsigned KIND_WIDTH  = 3;
   localparam int unsigned CSR_IDX_WIDTH = 2;

   localparam logic [ALIGN_WIDTH-1:0] DEF_SECTION_ALIGN = 32'h0000_1000;
   localparam logic [ALIGN_WIDTH-1:0] DEF_FILE_ALIGN    = 32'h0000_0200;
   localparam logic [ADDR_WIDTH-1:0]  DEF_BASE          = 64'h0000_0000_0040_0000;

   // configuration register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SECTION_ALIGN = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_FILE_ALIGN    = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BASE_ADDRESS  = 2'd2;

   // section kinds
   localparam logic [KIND_WIDTH-1:0] KIND_CODE   = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_RODATA = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_DATA   = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_BSS    = 3'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_TDATA  = 3'd4;
   localparam logic [KIND_WIDTH-1:0] KIND_TBSS   = 3'd5;

   // segment classes
   localparam logic [KIND_WIDTH-1:0] CLS_CODE   = 3'd0;
   localparam logic [KIND_WIDTH-1:0] CLS_RODATA = 3'd1;
   localparam logic [KIND_WIDTH-1:0] CLS_DATA   = 3'd2;
   localparam logic [KIND_WIDTH-1:0] CLS_BSS    = 3'd3;
   localparam logic [KIND_WIDTH-1:0] CLS_TLS    = 3'd4;

   // operation handed to the round-up unit
   typedef struct packed {
      logic                   start;
      logic [ADDR_WIDTH-1:0]  value;
      logic [ALIGN_WIDTH-1:0] align;
   } sil_op_type;

   function automatic logic [KIND_WIDTH-1:0] classify(input logic [KIND_WIDTH-1:0] kind);
      logic [KIND_WIDTH-1:0] cls;
      case (kind)
         KIND_CODE:   cls = CLS_CODE;
         KIND_RODATA: cls = CLS_RODATA;
         KIND_DATA:   cls = CLS_DATA;
         KIND_BSS:    cls = CLS_BSS;
         KIND_TDATA:  cls = CLS_TLS;
         KIND_TBSS:   cls = CLS_TLS;
         default:     cls = CLS_DATA;
      endcase
      return cls;
   endfunction

endpackage

// File: sv/sil_roundup.sv
// sil_roundup: rounds a 64-bit value up to a 32-bit alignment, saturating.
// Remainder by a restoring radix-2 loop, one bit a cycle. Uses sil_pkg.
module sil_roundup (
   input  logic                              clock,
   input  logic                              reset,
   input  sil_pkg::sil_op_type               op,
   output logic                              done,
   output logic [sil_pkg::ADDR_WIDTH-1:0]    result
);

   localparam int unsigned CNT_WIDTH = $clog2(sil_pkg::ADDR_WIDTH);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [CNT_WIDTH-1:0]            cnt_ff, cnt_in;
   logic [sil_pkg::ADDR_WIDTH-1:0]  val_ff, val_in;
   logic [sil_pkg::ALIGN_WIDTH-1:0] div_ff, div_in;
   logic [sil_pkg::ALIGN_WIDTH-1:0] rem_ff, rem_in;

   logic [sil_pkg::ALIGN_WIDTH:0]   trial;
   logic [sil_pkg::ALIGN_WIDTH:0]   diff;
   logic [sil_pkg::ALIGN_WIDTH-1:0] pad;
   logic [sil_pkg::ADDR_WIDTH:0]    sum;

   assign trial = {rem_ff, val_ff[sil_pkg::ADDR_WIDTH-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (op.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         val_in  = op.value;
         div_in  = op.align;
         rem_in  = '0;
      end else if (busy_ff) begin
         // rotate so the value is back in place after the last step
         val_in = {val_ff[sil_pkg::ADDR_WIDTH-2:0], val_ff[sil_pkg::ADDR_WIDTH-1]};
         rem_in = (trial >= {1'b0, div_ff}) ? diff[sil_pkg::ALIGN_WIDTH-1:0]
                                            : trial[sil_pkg::ALIGN_WIDTH-1:0];
         cnt_in = cnt_ff + CNT_WIDTH'(1);
         if (cnt_ff == CNT_WIDTH'(sil_pkg::ADDR_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      val_ff <= val_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign pad = (rem_ff == '0) ? '0 : (div_ff - rem_ff);
   assign sum = {1'b0, val_ff} + {{(sil_pkg::ADDR_WIDTH - sil_pkg::ALIGN_WIDTH + 1){1'b0}}, pad};

   always_comb begin
      if (div_ff == '0) begin
         result = val_ff;
      end else if (sum[sil_pkg::ADDR_WIDTH]) begin
         result = '1;
      end else begin
         result = sum[sil_pkg::ADDR_WIDTH-1:0];
      end
   end

   assign done = done_ff;

endmodule

// File: sv/section_image_layout_core.sv
// section_image_layout_core: assigns address, file offset and segment to
// each section of an image and reports image totals on the last one.
// Uses sil_pkg and sil_roundup.
//
//   channel  | direction | handshake                  | carries
//   req_*    | in        | req_valid / req_ready      | one section description
//   rsp_*    | out       | rsp_valid / rsp_ready      | placement and image totals
//   csr_*    | in        | csr_write_enable           | one register write
//
// A request runs four roundings in the shared remainder unit, each a start,
// 64 one-bit steps and a result, plus accept, update and output states; a last
// section also passes through the bounds and totals states.
// req_ready is high only while the sequencer is idle.
// A finished response sits in the output register; the next request is
// taken meanwhile and only its final load waits for rsp_ready.
// Reset is synchronous; the first request after reset opens a fresh image.
module section_image_layout_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [sil_pkg::KIND_WIDTH-1:0]        req_section_kind,
   input  logic [sil_pkg::ALIGN_WIDTH-1:0]       req_section_alignment_req,
   input  logic [sil_pkg::ADDR_WIDTH-1:0]        req_section_size,
   input  logic                                  req_last_section,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [sil_pkg::ADDR_WIDTH-1:0]        rsp_section_address,
   output logic [sil_pkg::ADDR_WIDTH-1:0]        rsp_section_file_offset,
   output logic [sil_pkg::ADDR_WIDTH-1:0]        rsp_section_file_bytes,
   output logic [sil_pkg::KIND_WIDTH-1:0]        rsp_segment_class,
   output logic                                  rsp_is_last,
   output logic [sil_pkg::ADDR_WIDTH-1:0]        rsp_image_size,
   output logic [sil_pkg::ADDR_WIDTH-1:0]        rsp_file_size,
   output logic [sil_pkg::ADDR_WIDTH-1:0]        rsp_code_end,
   output logic [sil_pkg::ADDR_WIDTH-1:0]        rsp_data_start,
   output logic [sil_pkg::ADDR_WIDTH-1:0]        rsp_data_end,
   input  logic                                  csr_write_enable,
   input  logic [sil_pkg::CSR_IDX_WIDTH-1:0]     csr_index,
   input  logic [sil_pkg::ADDR_WIDTH-1:0]        csr_write_data
);

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_VA   = 9'b000000010,
      ST_FO   = 9'b000000100,
      ST_SZS  = 9'b000001000,
      ST_SZF  = 9'b000010000,
      ST_UPD  = 9'b000100000,
      ST_BND  = 9'b001000000,
      ST_TOT  = 9'b010000000,
      ST_OUT  = 9'b100000000
   } state_type;

   typedef logic [sil_pkg::ADDR_WIDTH-1:0]  addr_type;
   typedef logic [sil_pkg::ALIGN_WIDTH-1:0] align_type;
   typedef logic [sil_pkg::KIND_WIDTH-1:0]  kind_type;

   state_type state_ff, state_in;
   logic      go_ff, go_in;
   logic      image_open_ff, image_open_in;
   logic      data_seen_ff, data_seen_in;

   align_type salign_ff, falign_ff;
   addr_type  base_ff;

   addr_type  ra_ff, ra_in;
   addr_type  rfo_ff, rfo_in;
   addr_type  code_end_ff, code_end_in;
   addr_type  first_data_ff, first_data_in;
   addr_type  data_end_ff, data_end_in;
   kind_type  kind_ff, kind_in;
   align_type req_align_ff, req_align_in;
   addr_type  size_ff, size_in;
   logic      last_ff, last_in;
   addr_type  va_ff, va_in;
   addr_type  fo_ff, fo_in;
   addr_type  sec_end_ff, sec_end_in;
   addr_type  ds_ff, ds_in;
   addr_type  de_ff, de_in;

   logic      rsp_valid_ff, rsp_valid_in;
   addr_type  rsp_address_ff, rsp_offset_ff, rsp_bytes_ff;
   kind_type  rsp_class_ff;
   logic      rsp_last_ff;
   addr_type  rsp_image_ff, rsp_fsize_ff, rsp_code_end_ff, rsp_ds_ff, rsp_de_ff;

   sil_pkg::sil_op_type op;
   logic      unit_done;
   addr_type  unit_result;

   align_type falign_eff;
   addr_type  base_eff;
   kind_type  cls;
   logic      nofile;
   logic      out_free;
   logic      load_out;

   assign falign_eff = (falign_ff == '0) ? sil_pkg::DEF_FILE_ALIGN : falign_ff;
   assign base_eff   = (base_ff == '0) ? sil_pkg::DEF_BASE : base_ff;
   assign cls        = sil_pkg::classify(kind_ff);
   assign nofile     = (kind_ff == sil_pkg::KIND_BSS) || (kind_ff == sil_pkg::KIND_TBSS);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign load_out   = (state_ff == ST_OUT) && out_free;
   assign req_ready  = (state_ff == ST_IDLE);

   // operand selection for the shared round-up unit
   always_comb begin
      op.start = go_ff;
      case (state_ff)
         ST_VA: begin
            op.value = ra_ff;
            op.align = (req_align_ff != '0) ? req_align_ff : salign_ff;
         end
         ST_FO: begin
            op.value = rfo_ff;
            op.align = falign_eff;
         end
         ST_SZS: begin
            op.value = size_ff;
            op.align = salign_ff;
         end
         ST_SZF: begin
            op.value = size_ff;
            op.align = falign_eff;
         end
         default: begin
            op.value = size_ff;
            op.align = salign_ff;
         end
      endcase
   end

   sil_roundup u_roundup (
      .clock  (clock),
      .reset  (reset),
      .op     (op),
      .done   (unit_done),
      .result (unit_result)
   );

   always_comb begin
      state_in      = state_ff;
      go_in         = 1'b0;
      image_open_in = image_open_ff;
      data_seen_in  = data_seen_ff;
      ra_in         = ra_ff;
      rfo_in        = rfo_ff;
      code_end_in   = code_end_ff;
      first_data_in = first_data_ff;
      data_end_in   = data_end_ff;
      kind_in       = kind_ff;
      req_align_in  = req_align_ff;
      size_in       = size_ff;
      last_in       = last_ff;
      va_in         = va_ff;
      fo_in         = fo_ff;
      sec_end_in    = sec_end_ff;
      ds_in         = ds_ff;
      de_in         = de_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in      = req_section_kind;
               req_align_in = req_section_alignment_req;
               size_in      = req_section_size;
               last_in      = req_last_section;
               if (!image_open_ff) begin
                  // fresh image: load running values from the registers
                  ra_in = base_eff + addr_type'(salign_ff);
                  rfo_in = addr_type'(salign_ff);
                  code_end_in = base_eff + addr_type'(salign_ff);
                  first_data_in = '0;
                  data_end_in = '0;
                  data_seen_in = 1'b0;
                  image_open_in = 1'b1;
               end
               state_in = ST_VA;
               go_in    = 1'b1;
            end
         end
         ST_VA: begin
            if (unit_done) begin
               va_in    = unit_result;
               state_in = ST_FO;
               go_in    = 1'b1;
            end
         end
         ST_FO: begin
            if (unit_done) begin
               fo_in    = unit_result;
               state_in = ST_SZS;
               go_in    = 1'b1;
            end
         end
         ST_SZS: begin
            if (unit_done) begin
               sec_end_in = va_ff + unit_result;
               state_in   = ST_SZF;
               go_in      = 1'b1;
            end
         end
         ST_SZF: begin
            if (unit_done) begin
               rfo_in   = nofile ? fo_ff : (fo_ff + unit_result);
               ra_in    = sec_end_ff;
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (cls == sil_pkg::CLS_CODE || cls == sil_pkg::CLS_RODATA) begin
               if (sec_end_ff > code_end_ff) begin
                  code_end_in = sec_end_ff;
               end
            end else begin
               if (!data_seen_ff || va_ff < first_data_ff) begin
                  first_data_in = va_ff;
               end
               if (!data_seen_ff || sec_end_ff > data_end_ff) begin
                  data_end_in = sec_end_ff;
               end
               data_seen_in = 1'b1;
            end
            state_in = last_ff ? ST_BND : ST_OUT;
         end
         ST_BND: begin
            ds_in = (data_seen_ff && first_data_ff < ra_ff) ? first_data_ff : ra_ff;
            de_in = (data_seen_ff && data_end_ff > ra_ff) ? data_end_ff : ra_ff;
            state_in = ST_TOT;
         end
         ST_TOT: begin
            // empty data segment collapses onto the code end
            if (ds_ff >= de_ff) begin
               ds_in = code_end_ff;
               de_in = code_end_ff;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               if (last_ff) begin
                  image_open_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         go_ff         <= 1'b0;
         image_open_ff <= 1'b0;
         data_seen_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         salign_ff     <= sil_pkg::DEF_SECTION_ALIGN;
         falign_ff     <= sil_pkg::DEF_FILE_ALIGN;
         base_ff       <= sil_pkg::DEF_BASE;
      end else begin
         state_ff      <= state_in;
         go_ff         <= go_in;
         image_open_ff <= image_open_in;
         data_seen_ff  <= data_seen_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               sil_pkg::CSR_SECTION_ALIGN: salign_ff <= csr_write_data[sil_pkg::ALIGN_WIDTH-1:0];
               sil_pkg::CSR_FILE_ALIGN:    falign_ff <= csr_write_data[sil_pkg::ALIGN_WIDTH-1:0];
               sil_pkg::CSR_BASE_ADDRESS:  base_ff   <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      ra_ff         <= ra_in;
      rfo_ff        <= rfo_in;
      code_end_ff   <= code_end_in;
      first_data_ff <= first_data_in;
      data_end_ff   <= data_end_in;
      kind_ff       <= kind_in;
      req_align_ff  <= req_align_in;
      size_ff       <= size_in;
      last_ff       <= last_in;
      va_ff         <= va_in;
      fo_ff         <= fo_in;
      sec_end_ff    <= sec_end_in;
      ds_ff         <= ds_in;
      de_ff         <= de_in;
      if (load_out) begin
         rsp_address_ff <= va_ff;
         rsp_offset_ff  <= fo_ff;
         rsp_bytes_ff   <= nofile ? '0 : size_ff;
         rsp_class_ff   <= cls;
         rsp_last_ff    <= last_ff;
         if (last_ff) begin
            rsp_image_ff    <= de_ff - base_eff;
            rsp_fsize_ff    <= rfo_ff;
            rsp_code_end_ff <= code_end_ff;
            rsp_ds_ff       <= ds_ff;
            rsp_de_ff       <= de_ff;
         end else begin
            rsp_image_ff    <= '0;
            rsp_fsize_ff    <= '0;
            rsp_code_end_ff <= '0;
            rsp_ds_ff       <= '0;
            rsp_de_ff       <= '0;
         end
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_section_address     = rsp_address_ff;
   assign rsp_section_file_offset = rsp_offset_ff;
   assign rsp_section_file_bytes  = rsp_bytes_ff;
   assign rsp_segment_class       = rsp_class_ff;
   assign rsp_is_last             = rsp_last_ff;
   assign rsp_image_size          = rsp_image_ff;
   assign rsp_file_size           = rsp_fsize_ff;
   assign rsp_code_end            = rsp_code_end_ff;
   assign rsp_data_start          = rsp_ds_ff;
   assign rsp_data_end            = rsp_de_ff;

   // a taken request starts the unit on the next cycle
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (go_ff && !req_ready))
      else $error("request accepted without starting the round-up unit");

   // the unit only finishes inside a rounding step
   a_done_in_round: assert property (@(posedge clock) disable iff (reset)
      unit_done |-> (state_ff == ST_VA || state_ff == ST_FO ||
                     state_ff == ST_SZS || state_ff == ST_SZF))
      else $error("round-up unit finished outside a rounding step");

   // totals only on the last section of an image
   a_totals_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_last) |-> (rsp_image_size == '0 && rsp_file_size == '0 &&
                                       rsp_data_start == '0 && rsp_data_end == '0))
      else $error("image totals set on a non-final section");

   // data segment bounds are ordered
   a_data_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_last) |-> (rsp_data_start <= rsp_data_end))
      else $error("data segment start beyond its end");

endmodule

// File: dv/section_image_layout_core_tb.sv
// section_image_layout_core_tb: self-checking bench for the section layout core.
// A layout model predicts every placement and image total; depends on sil_pkg
// and the section_image_layout_core RTL.
`timescale 1ns / 100ps

module section_image_layout_core_tb;

   localparam logic [sil_pkg::KIND_WIDTH-1:0]    KIND_OTHER = 3'd6;
   localparam logic [sil_pkg::KIND_WIDTH-1:0]    KIND_SPARE = 3'd7;
   localparam logic [sil_pkg::CSR_IDX_WIDTH-1:0] CSR_UNUSED = 2'd3;

   localparam int ITEMS_PER_PHASE = 105;
   localparam int NUM_PHASES      = 8;
   localparam int HOLD_CYCLES     = 3000;
   localparam int QUIET_LIMIT     = 20000;
   localparam int DRAIN_CYCLES    = 300;
   localparam int MAX_REPORTS     = 40;

   typedef struct packed {
      logic [sil_pkg::KIND_WIDTH-1:0]  kind;
      logic [sil_pkg::ALIGN_WIDTH-1:0] align_req;
      logic [sil_pkg::ADDR_WIDTH-1:0]  size;
      logic                            last;
   } section_req_type;

   typedef struct packed {
      logic [sil_pkg::ADDR_WIDTH-1:0] address;
      logic [sil_pkg::ADDR_WIDTH-1:0] file_pos;
      logic [sil_pkg::ADDR_WIDTH-1:0] file_bytes;
      logic [sil_pkg::KIND_WIDTH-1:0] seg_class;
      logic                           is_last;
      logic [sil_pkg::ADDR_WIDTH-1:0] image_span;
      logic [sil_pkg::ADDR_WIDTH-1:0] file_extent;
      logic [sil_pkg::ADDR_WIDTH-1:0] code_end;
      logic [sil_pkg::ADDR_WIDTH-1:0] data_start;
      logic [sil_pkg::ADDR_WIDTH-1:0] data_end;
   } placement_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [sil_pkg::KIND_WIDTH-1:0]    req_section_kind = '0;
   logic [sil_pkg::ALIGN_WIDTH-1:0]   req_section_alignment_req = '0;
   logic [sil_pkg::ADDR_WIDTH-1:0]    req_section_size = '0;
   logic                              req_last_section = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [sil_pkg::ADDR_WIDTH-1:0]    rsp_section_address;
   logic [sil_pkg::ADDR_WIDTH-1:0]    rsp_section_file_offset;
   logic [sil_pkg::ADDR_WIDTH-1:0]    rsp_section_file_bytes;
   logic [sil_pkg::KIND_WIDTH-1:0]    rsp_segment_class;
   logic                              rsp_is_last;
   logic [sil_pkg::ADDR_WIDTH-1:0]    rsp_image_size;
   logic [sil_pkg::ADDR_WIDTH-1:0]    rsp_file_size;
   logic [sil_pkg::ADDR_WIDTH-1:0]    rsp_code_end;
   logic [sil_pkg::ADDR_WIDTH-1:0]    rsp_data_start;
   logic [sil_pkg::ADDR_WIDTH-1:0]    rsp_data_end;
   logic                              csr_write_enable = 1'b0;
   logic [sil_pkg::CSR_IDX_WIDTH-1:0] csr_index = '0;
   logic [sil_pkg::ADDR_WIDTH-1:0]    csr_write_data = '0;

   section_image_layout_core u_top (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_ready                 (req_ready),
      .req_section_kind          (req_section_kind),
      .req_section_alignment_req (req_section_alignment_req),
      .req_section_size          (req_section_size),
      .req_last_section          (req_last_section),
      .rsp_valid                 (rsp_valid),
      .rsp_ready                 (rsp_ready),
      .rsp_section_address       (rsp_section_address),
      .rsp_section_file_offset   (rsp_section_file_offset),
      .rsp_section_file_bytes    (rsp_section_file_bytes),
      .rsp_segment_class         (rsp_segment_class),
      .rsp_is_last               (rsp_is_last),
      .rsp_image_size            (rsp_image_size),
      .rsp_file_size             (rsp_file_size),
      .rsp_code_end              (rsp_code_end),
      .rsp_data_start            (rsp_data_start),
      .rsp_data_end              (rsp_data_end),
      .csr_write_enable          (csr_write_enable),
      .csr_index                 (csr_index),
      .csr_write_data            (csr_write_data)
   );

   // register shadows and layout model state
   logic [sil_pkg::ALIGN_WIDTH-1:0] cfg_section_align;
   logic [sil_pkg::ALIGN_WIDTH-1:0] cfg_file_align;
   logic [sil_pkg::ADDR_WIDTH-1:0]  cfg_base;
   logic [sil_pkg::ADDR_WIDTH-1:0]  lay_addr;
   logic [sil_pkg::ADDR_WIDTH-1:0]  lay_file_off;
   logic [sil_pkg::ADDR_WIDTH-1:0]  lay_code_end;
   logic [sil_pkg::ADDR_WIDTH-1:0]  lay_data_first;
   logic [sil_pkg::ADDR_WIDTH-1:0]  lay_data_end;
   logic                            lay_data_seen;
   logic                            lay_image_open;

   section_req_type pending_sections[$];
   placement_type   expected_placements[$];
   section_req_type on_offer;
   placement_type   rsp_seen;
   placement_type   rsp_want;

   logic no_idle = 1'b0;
   logic offering;
   logic ready_next;
   int   send_wait = 0;
   int   recv_wait = 0;
   int   hold_requests = 0;
   int   hold_seen = 0;
   int   hold_left = 0;
   int   sections_sent = 0;
   int   responses_seen = 0;
   int   images_closed = 0;
   int   settings_applied = 0;
   int   mismatches = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [sil_pkg::ADDR_WIDTH-1:0] round_up_to(
         input logic [sil_pkg::ADDR_WIDTH-1:0] v,
         input logic [sil_pkg::ADDR_WIDTH-1:0] a);
      logic [sil_pkg::ADDR_WIDTH-1:0] rem;
      logic [sil_pkg::ADDR_WIDTH-1:0] pad;
      if (a == '0)
         return v;
      if ((a & (a - 64'd1)) == '0)
         rem = v & (a - 64'd1);
      else
         rem = v % a;
      pad = (rem != '0) ? a - rem : '0;
      // saturate instead of wrapping past the top of the address space
      return (v > ~pad) ? '1 : v + pad;
   endfunction

   task automatic reset_layout_model();
      cfg_section_align = sil_pkg::DEF_SECTION_ALIGN;
      cfg_file_align    = sil_pkg::DEF_FILE_ALIGN;
      cfg_base          = sil_pkg::DEF_BASE;
      lay_addr          = sil_pkg::DEF_BASE + {32'd0, sil_pkg::DEF_SECTION_ALIGN};
      lay_file_off      = {32'd0, sil_pkg::DEF_SECTION_ALIGN};
      lay_code_end      = lay_addr;
      lay_data_first    = '0;
      lay_data_end      = '0;
      lay_data_seen     = 1'b0;
      lay_image_open    = 1'b0;
   endtask

   function automatic placement_type place_section(input section_req_type s);
      logic [sil_pkg::ADDR_WIDTH-1:0] salign;
      logic [sil_pkg::ADDR_WIDTH-1:0] falign;
      logic [sil_pkg::ADDR_WIDTH-1:0] base;
      logic [sil_pkg::ADDR_WIDTH-1:0] align;
      logic [sil_pkg::ADDR_WIDTH-1:0] va;
      logic [sil_pkg::ADDR_WIDTH-1:0] fo;
      logic [sil_pkg::ADDR_WIDTH-1:0] sec_end;
      logic [sil_pkg::ADDR_WIDTH-1:0] ds;
      logic [sil_pkg::ADDR_WIDTH-1:0] de;
      logic [sil_pkg::KIND_WIDTH-1:0] cls;
      logic                           nofile;
      placement_type                  p;
      salign = {32'd0, cfg_section_align};
      falign = (cfg_file_align != '0) ? {32'd0, cfg_file_align}
                                      : {32'd0, sil_pkg::DEF_FILE_ALIGN};
      base   = (cfg_base != '0) ? cfg_base : sil_pkg::DEF_BASE;
      if (!lay_image_open) begin
         lay_addr       = base + salign;
         lay_file_off   = salign;
         lay_code_end   = lay_addr;
         lay_data_first = '0;
         lay_data_end   = '0;
         lay_data_seen  = 1'b0;
         lay_image_open = 1'b1;
      end
      case (s.kind)
         sil_pkg::KIND_CODE:   cls = sil_pkg::CLS_CODE;
         sil_pkg::KIND_RODATA: cls = sil_pkg::CLS_RODATA;
         sil_pkg::KIND_DATA:   cls = sil_pkg::CLS_DATA;
         sil_pkg::KIND_BSS:    cls = sil_pkg::CLS_BSS;
         sil_pkg::KIND_TDATA:  cls = sil_pkg::CLS_TLS;
         sil_pkg::KIND_TBSS:   cls = sil_pkg::CLS_TLS;
         default:              cls = sil_pkg::CLS_DATA;
      endcase
      align   = (s.align_req != '0) ? {32'd0, s.align_req} : salign;
      va      = round_up_to(lay_addr, align);
      fo      = round_up_to(lay_file_off, falign);
      nofile  = (s.kind == sil_pkg::KIND_BSS) || (s.kind == sil_pkg::KIND_TBSS);
      sec_end = va + round_up_to(s.size, salign);
      lay_addr     = sec_end;
      lay_file_off = nofile ? fo : fo + round_up_to(s.size, falign);
      if (cls == sil_pkg::CLS_CODE || cls == sil_pkg::CLS_RODATA) begin
         if (sec_end > lay_code_end)
            lay_code_end = sec_end;
      end else begin
         if (!lay_data_seen || va < lay_data_first)
            lay_data_first = va;
         if (!lay_data_seen || sec_end > lay_data_end)
            lay_data_end = sec_end;
         lay_data_seen = 1'b1;
      end
      p            = '0;
      p.address    = va;
      p.file_pos   = fo;
      p.file_bytes = nofile ? '0 : s.size;
      p.seg_class  = cls;
      p.is_last    = s.last;
      if (s.last) begin
         ds = lay_addr;
         de = lay_addr;
         if (lay_data_seen) begin
            if (lay_data_first < ds)
               ds = lay_data_first;
            if (lay_data_end > de)
               de = lay_data_end;
         end
         // no data bytes: both bounds collapse onto the code end
         if (ds >= de) begin
            ds = lay_code_end;
            de = lay_code_end;
         end
         p.image_span   = de - base;
         p.file_extent  = lay_file_off;
         p.code_end     = lay_code_end;
         p.data_start   = ds;
         p.data_end     = de;
         lay_image_open = 1'b0;
      end
      return p;
   endfunction

   task automatic push_section(input logic [sil_pkg::KIND_WIDTH-1:0] kind,
                               input logic [sil_pkg::ALIGN_WIDTH-1:0] align_req,
                               input logic [sil_pkg::ADDR_WIDTH-1:0] size,
                               input logic last);
      section_req_type s;
      s.kind      = kind;
      s.align_req = align_req;
      s.size      = size;
      s.last      = last;
      pending_sections.push_back(s);
   endtask

   function automatic section_req_type random_section();
      section_req_type                s;
      logic [31:0]                    r;
      logic [sil_pkg::ADDR_WIDTH-1:0] w;
      r = $urandom;
      w = {$urandom, $urandom};
      s.kind = r[2:0];
      case (r[6:4])
         3'd0, 3'd1: s.align_req = '0;
         3'd2, 3'd3: s.align_req = 32'd1 << r[12:8];
         3'd4:       s.align_req = {20'd0, w[11:0]};
         3'd5:       s.align_req = w[31:0];
         3'd6:       s.align_req = '1;
         default:    s.align_req = {27'd0, w[4:0]};
      endcase
      case (r[15:13])
         3'd0:             s.size = '0;
         3'd1, 3'd2, 3'd3: s.size = {48'd0, w[47:32]};
         3'd4:             s.size = {32'd0, w[63:32]};
         3'd5:             s.size = 64'd1 << r[21:16];
         3'd6:             s.size = w;
         default:          s.size = ~{56'd0, w[39:32]};
      endcase
      s.last = 1'b0;
      return s;
   endfunction

   // mostly whole images of one to eight sections, some with a stray last flag
   task automatic queue_images(input int count);
      section_req_type s;
      logic [31:0]     r;
      int              left_in_image;
      left_in_image = 0;
      for (int i = 0; i < count; i++) begin
         if (left_in_image == 0)
            left_in_image = $urandom_range(1, 8);
         s = random_section();
         left_in_image--;
         r = $urandom;
         if (r[7:0] < 8'd36)
            s.last = r[8];
         else
            s.last = (left_in_image == 0);
         pending_sections.push_back(s);
      end
   endtask

   task automatic wait_idle();
      while (pending_sections.size() != 0 || req_valid || expected_placements.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [sil_pkg::CSR_IDX_WIDTH-1:0] idx,
                            input logic [sil_pkg::ADDR_WIDTH-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         sil_pkg::CSR_SECTION_ALIGN: cfg_section_align = data[31:0];
         sil_pkg::CSR_FILE_ALIGN:    cfg_file_align = data[31:0];
         sil_pkg::CSR_BASE_ADDRESS:  cfg_base = data;
         default: ;
      endcase
   endtask

   task automatic configure_phase(input int phase);
      logic [31:0]                    r1;
      logic [31:0]                    r2;
      logic [sil_pkg::ADDR_WIDTH-1:0] w;
      logic [31:0]                    sa;
      logic [31:0]                    fa;
      logic [sil_pkg::ADDR_WIDTH-1:0] b;
      r1 = $urandom;
      r2 = $urandom;
      w  = {$urandom, $urandom};
      case (phase)
         0: begin
            sa = sil_pkg::DEF_SECTION_ALIGN; fa = sil_pkg::DEF_FILE_ALIGN;
            b = sil_pkg::DEF_BASE;
         end
         1: begin
            sa = 32'd1 << r1[4:0]; fa = 32'd1 << r1[12:8]; b = w;
         end
         2: begin
            sa = '0; fa = '0; b = '0;
         end
         3: begin
            sa = {20'd0, r1[11:0]}; fa = {22'd0, r2[9:0]}; b = {32'd0, r2};
         end
         4: begin
            sa = '1; fa = 32'd1; b = '1;
         end
         5: begin
            sa = 32'd1; fa = '1; b = {w[63:12], 12'd0};
         end
         6: begin
            sa = r1; fa = r2; b = w;
         end
         default: begin
            sa = {24'd0, r1[7:0]}; fa = {24'd0, r2[7:0]}; b = {16'hFFFF, w[47:0]};
         end
      endcase
      // upper bits of the narrow registers must be dropped
      write_csr(sil_pkg::CSR_SECTION_ALIGN, {r2, sa});
      write_csr(sil_pkg::CSR_FILE_ALIGN, {r1, fa});
      write_csr(sil_pkg::CSR_BASE_ADDRESS, b);
      settings_applied++;
   endtask

   task automatic report_mismatch(input string what,
                                  input logic [sil_pkg::ADDR_WIDTH-1:0] got_v,
                                  input logic [sil_pkg::ADDR_WIDTH-1:0] want_v);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("response %0d: %s is %h, expected %h", responses_seen, what, got_v, want_v);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         offering = req_valid;
         if (req_valid && req_ready) begin
            expected_placements.push_back(place_section(on_offer));
            sections_sent++;
            offering = 1'b0;
            send_wait = no_idle ? 0 : $urandom_range(0, 19);
         end
         if (!offering) begin
            if (send_wait > 0)
               send_wait--;
            else if (pending_sections.size() != 0) begin
               on_offer = pending_sections.pop_front();
               req_section_kind          <= on_offer.kind;
               req_section_alignment_req <= on_offer.align_req;
               req_section_size          <= on_offer.size;
               req_last_section          <= on_offer.last;
               offering = 1'b1;
            end
         end
         req_valid <= offering;
      end
   end

   // response monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            responses_seen++;
            rsp_seen.address     = rsp_section_address;
            rsp_seen.file_pos    = rsp_section_file_offset;
            rsp_seen.file_bytes  = rsp_section_file_bytes;
            rsp_seen.seg_class   = rsp_segment_class;
            rsp_seen.is_last     = rsp_is_last;
            rsp_seen.image_span  = rsp_image_size;
            rsp_seen.file_extent = rsp_file_size;
            rsp_seen.code_end    = rsp_code_end;
            rsp_seen.data_start  = rsp_data_start;
            rsp_seen.data_end    = rsp_data_end;
            if (expected_placements.size() == 0) begin
               report_mismatch("unrequested response, address", rsp_seen.address, '0);
            end else begin
               rsp_want = expected_placements.pop_front();
               if (rsp_want.is_last)
                  images_closed++;
               if (rsp_seen.address !== rsp_want.address)
                  report_mismatch("section address", rsp_seen.address, rsp_want.address);
               if (rsp_seen.file_pos !== rsp_want.file_pos)
                  report_mismatch("section file offset", rsp_seen.file_pos,
                                  rsp_want.file_pos);
               if (rsp_seen.file_bytes !== rsp_want.file_bytes)
                  report_mismatch("section file bytes", rsp_seen.file_bytes,
                                  rsp_want.file_bytes);
               if (rsp_seen.seg_class !== rsp_want.seg_class)
                  report_mismatch("segment class", {61'd0, rsp_seen.seg_class},
                                  {61'd0, rsp_want.seg_class});
               if (rsp_seen.is_last !== rsp_want.is_last)
                  report_mismatch("last flag", {63'd0, rsp_seen.is_last},
                                  {63'd0, rsp_want.is_last});
               if (rsp_seen.image_span !== rsp_want.image_span)
                  report_mismatch("image span", rsp_seen.image_span, rsp_want.image_span);
               if (rsp_seen.file_extent !== rsp_want.file_extent)
                  report_mismatch("file extent", rsp_seen.file_extent,
                                  rsp_want.file_extent);
               if (rsp_seen.code_end !== rsp_want.code_end)
                  report_mismatch("code end", rsp_seen.code_end, rsp_want.code_end);
               if (rsp_seen.data_start !== rsp_want.data_start)
                  report_mismatch("data start", rsp_seen.data_start, rsp_want.data_start);
               if (rsp_seen.data_end !== rsp_want.data_end)
                  report_mismatch("data end", rsp_seen.data_end, rsp_want.data_end);
            end
            recv_wait = no_idle ? 0 : $urandom_range(0, 19);
         end
         if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait--;
            ready_next = 1'b0;
         end else begin
            ready_next = 1'b1;
         end
         rsp_ready <= ready_next;
      end
   end

   // ends the run if nothing moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable)
            quiet = 0;
         else
            quiet++;
      end
      $display("no request or response moved for %0d cycles", QUIET_LIMIT);
      $display("section_image_layout_core_tb: FAIL");
      $finish;
   end

   initial begin : stimulus
      int phase;
      reset_layout_model();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // register values from reset: every kind, odd and extreme alignments
      push_section(sil_pkg::KIND_CODE,   32'd0,         64'd0,      1'b0);
      push_section(sil_pkg::KIND_RODATA, 32'd1,         64'd1,      1'b0);
      push_section(sil_pkg::KIND_DATA,   32'd3,         64'd100,    1'b0);
      push_section(sil_pkg::KIND_BSS,    32'h10,        64'd5000,   1'b0);
      push_section(sil_pkg::KIND_TDATA,  32'h8000_0000, 64'h1_0001, 1'b0);
      push_section(sil_pkg::KIND_TBSS,   32'hFFFF_FFFF, 64'd7,      1'b0);
      push_section(KIND_OTHER,           32'd0,         64'd64,     1'b0);
      push_section(KIND_SPARE,           32'd48,        64'd12,     1'b1);
      // code only, so the data bounds fall back to the code end
      push_section(sil_pkg::KIND_CODE,   32'd0,         64'h1234,   1'b1);
      push_section(sil_pkg::KIND_BSS,    32'd0,         '1,         1'b1);
      // image left open across the register writes below
      push_section(sil_pkg::KIND_CODE,   32'd0,         64'd10,     1'b0);
      wait_idle();
      write_csr(sil_pkg::CSR_SECTION_ALIGN, {32'hDEAD_BEEF, 32'd0});
      write_csr(sil_pkg::CSR_FILE_ALIGN, '0);
      write_csr(sil_pkg::CSR_BASE_ADDRESS, '0);
      write_csr(CSR_UNUSED, '1);
      settings_applied++;
      // zero section alignment: addresses and sizes go unrounded
      push_section(sil_pkg::KIND_DATA,   32'd0,         64'd33,     1'b0);
      push_section(sil_pkg::KIND_RODATA, 32'd0,         64'd5,      1'b1);
      push_section(sil_pkg::KIND_DATA,   32'd0,         64'd9,      1'b1);
      wait_idle();
      write_csr(sil_pkg::CSR_SECTION_ALIGN, 64'h10);
      write_csr(sil_pkg::CSR_FILE_ALIGN, 64'hFFFF_FFFF);
      write_csr(sil_pkg::CSR_BASE_ADDRESS, 64'hFFFF_FFFF_FFFF_FF00);
      settings_applied++;
      // rounding near the top of the address space saturates
      push_section(sil_pkg::KIND_CODE,   32'h1000,      64'd1,      1'b0);
      push_section(sil_pkg::KIND_DATA,   32'd7,         64'd1,      1'b0);
      push_section(sil_pkg::KIND_TDATA,  32'd0,         64'hFF,     1'b0);
      push_section(sil_pkg::KIND_CODE,   32'd1,         64'd0,      1'b1);

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         // sender waits for every outstanding response before reprogramming
         wait_idle();
         configure_phase(phase);
         no_idle = (phase == 2 || phase == 3 || phase == 5);
         queue_images(ITEMS_PER_PHASE);
         // receiver stalls for a long stretch while requests keep coming
         if (phase == 3)
            hold_requests <= hold_requests + 1;
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d sections laid out under %0d register settings, %0d image totals checked",
               sections_sent, settings_applied, images_closed);
      $display("%0d responses received, %0d mismatches", responses_seen, mismatches);
      if (mismatches == 0)
         $display("section_image_layout_core_tb: PASS");
      else
         $display("section_image_layout_core_tb: FAIL");
      $finish;
   end

endmodule
